// ----- sv/dcmmt_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths and types for the dual channel min/max/mean tracker.
// No dependencies; used by the top level, its checker and the bench.
package dcmmt_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
    localparam int STEP_BITS   = $clog2(SAMPLE_BITS);
    localparam int NUM_CH      = 2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [STEP_BITS-1:0]   step_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam step_t  LAST_STEP = STEP_BITS'(SAMPLE_BITS - 1);

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

endpackage

// ----- sv/dual_channel_min_max_mean_tracker.sv -----
`timescale 1ns / 1ps
// Dual channel running min / max / mean tracker, top level.
// Depends on dcmmt_pkg for widths, types and request codes.
//
// Usage:
//   s_ channel: one request beat per operation. s_req_type selects a
//   sample (both channels take s_sample_first / s_sample_second) or a
//   clear of the channel named by s_clear_channel.
//   m_ channel: exactly one result beat per request, with count, max,
//   min and mean of both channels as they stand after the request, plus
//   m_full_flag when a channel at its count limit dropped its sample.
// Timing:
//   Statistics update in the accept cycle. Each mean then comes from one
//   shared restoring divider, one quotient bit per cycle: a load step
//   plus SAMPLE_BITS divide steps per channel. The result register loads
//   from the output state after the second division, once it is free.
//   s_ready returns with m_valid: no new request is taken until the
//   result of the last one is loaded.
// Stall: the result register holds its beat until m_ready; a new request
//   is still accepted and computed meanwhile, and waits in the output
//   state until the register frees up.
// Reset: synchronous, active low aresetn clears peak, trough, count and
//   sum of both channels to zero, drops m_valid and returns the sequencer to idle.
module dual_channel_min_max_mean_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic                 s_clear_channel,
    input  dcmmt_pkg::sample_t   s_sample_first,
    input  dcmmt_pkg::sample_t   s_sample_second,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output dcmmt_pkg::count_t    m_count_first,
    output dcmmt_pkg::sample_t   m_max_first,
    output dcmmt_pkg::sample_t   m_min_first,
    output dcmmt_pkg::sample_t   m_mean_first,
    output dcmmt_pkg::count_t    m_count_second,
    output dcmmt_pkg::sample_t   m_max_second,
    output dcmmt_pkg::sample_t   m_min_second,
    output dcmmt_pkg::sample_t   m_mean_second,
    output logic                 m_full_flag
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    // per channel statistics
    dcmmt_pkg::sample_t peak_reg   [dcmmt_pkg::NUM_CH];
    dcmmt_pkg::sample_t trough_reg [dcmmt_pkg::NUM_CH];
    dcmmt_pkg::count_t  count_reg  [dcmmt_pkg::NUM_CH];
    dcmmt_pkg::sum_t    sum_reg    [dcmmt_pkg::NUM_CH];
    dcmmt_pkg::sample_t mean_reg   [dcmmt_pkg::NUM_CH];
    logic               full_reg;

    // shared divider: rem holds the partial remainder, quo shifts dividend
    // bits out at the top and quotient bits in at the bottom
    logic               ch_reg;
    dcmmt_pkg::step_t   step_reg;
    dcmmt_pkg::count_t  rem_reg;
    dcmmt_pkg::sample_t quo_reg;
    dcmmt_pkg::count_t  divisor_reg;

    // result register
    logic               m_valid_reg;
    dcmmt_pkg::count_t  m_count_first_reg;
    dcmmt_pkg::sample_t m_max_first_reg;
    dcmmt_pkg::sample_t m_min_first_reg;
    dcmmt_pkg::sample_t m_mean_first_reg;
    dcmmt_pkg::count_t  m_count_second_reg;
    dcmmt_pkg::sample_t m_max_second_reg;
    dcmmt_pkg::sample_t m_min_second_reg;
    dcmmt_pkg::sample_t m_mean_second_reg;
    logic               m_full_flag_reg;

    // one divider step
    logic [dcmmt_pkg::COUNT_BITS:0] rem_shift;
    logic                           quo_bit;
    dcmmt_pkg::count_t              rem_next;
    dcmmt_pkg::sample_t             quo_next;

    // sample intake
    logic               accept;
    dcmmt_pkg::sample_t samp [dcmmt_pkg::NUM_CH];
    logic               out_free;
    logic               full_next;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign samp[0]  = s_sample_first;
    assign samp[1]  = s_sample_second;

    // a sample request drops its sample on any channel sitting at the limit
    assign full_next = (s_req_type == dcmmt_pkg::REQ_SAMPLE)
                    && (count_reg[0] == dcmmt_pkg::COUNT_MAX
                     || count_reg[1] == dcmmt_pkg::COUNT_MAX);

    always_comb begin
        rem_shift = {rem_reg, quo_reg[dcmmt_pkg::SAMPLE_BITS-1]};
        quo_bit   = (rem_shift >= {1'b0, divisor_reg});
        if (quo_bit) begin
            rem_next = dcmmt_pkg::COUNT_BITS'(rem_shift - {1'b0, divisor_reg});
        end else begin
            rem_next = rem_shift[dcmmt_pkg::COUNT_BITS-1:0];
        end
        quo_next = {quo_reg[dcmmt_pkg::SAMPLE_BITS-2:0], quo_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            full_reg    <= 1'b0;
            ch_reg      <= 1'b0;
            step_reg    <= '0;
            for (int c = 0; c < dcmmt_pkg::NUM_CH; c++) begin
                peak_reg[c]   <= '0;
                trough_reg[c] <= '0;
                count_reg[c]  <= '0;
                sum_reg[c]    <= '0;
            end
        end else begin
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        full_reg <= full_next;
                        if (s_req_type == dcmmt_pkg::REQ_CLEAR) begin
                            peak_reg[s_clear_channel]   <= '0;
                            trough_reg[s_clear_channel] <= '0;
                            count_reg[s_clear_channel]  <= '0;
                            sum_reg[s_clear_channel]    <= '0;
                        end else begin
                            for (int c = 0; c < dcmmt_pkg::NUM_CH; c++) begin
                                if (count_reg[c] != dcmmt_pkg::COUNT_MAX) begin
                                    if (samp[c] > peak_reg[c]) begin
                                        peak_reg[c] <= samp[c];
                                    end
                                    if (count_reg[c] == '0 || samp[c] < trough_reg[c]) begin
                                        trough_reg[c] <= samp[c];
                                    end
                                    count_reg[c] <= count_reg[c] + 1'b1;
                                    sum_reg[c]   <= sum_reg[c] + dcmmt_pkg::sum_t'(samp[c]);
                                end
                            end
                        end
                        ch_reg    <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end

                ST_LOAD: begin
                    // upper sum bits start below the divisor since mean fits a sample
                    rem_reg     <= sum_reg[ch_reg][dcmmt_pkg::SUM_BITS-1:dcmmt_pkg::SAMPLE_BITS];
                    quo_reg     <= sum_reg[ch_reg][dcmmt_pkg::SAMPLE_BITS-1:0];
                    divisor_reg <= count_reg[ch_reg];
                    step_reg    <= '0;
                    state_reg   <= ST_DIV;
                end

                ST_DIV: begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == dcmmt_pkg::LAST_STEP) begin
                        // empty channel reads mean 0
                        mean_reg[ch_reg] <= (divisor_reg == '0) ? '0 : quo_next;
                        if (ch_reg) begin
                            state_reg <= ST_OUT;
                        end else begin
                            ch_reg    <= 1'b1;
                            state_reg <= ST_LOAD;
                        end
                    end
                end

                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg        <= 1'b1;
                        m_count_first_reg  <= count_reg[0];
                        m_max_first_reg    <= peak_reg[0];
                        m_min_first_reg    <= trough_reg[0];
                        m_mean_first_reg   <= mean_reg[0];
                        m_count_second_reg <= count_reg[1];
                        m_max_second_reg   <= peak_reg[1];
                        m_min_second_reg   <= trough_reg[1];
                        m_mean_second_reg  <= mean_reg[1];
                        m_full_flag_reg    <= full_reg;
                        state_reg          <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_count_first  = m_count_first_reg;
    assign m_max_first    = m_max_first_reg;
    assign m_min_first    = m_min_first_reg;
    assign m_mean_first   = m_mean_first_reg;
    assign m_count_second = m_count_second_reg;
    assign m_max_second   = m_max_second_reg;
    assign m_min_second   = m_min_second_reg;
    assign m_mean_second  = m_mean_second_reg;
    assign m_full_flag    = m_full_flag_reg;

endmodule

// ----- sv/dcmmt_checker.sv -----
`timescale 1ns / 1ps
// Port level checks for the dual channel min/max/mean tracker, bound to the top.
// Depends on dcmmt_pkg and dual_channel_min_max_mean_tracker.
module dcmmt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input dcmmt_pkg::count_t  m_count_first,
    input dcmmt_pkg::sample_t m_max_first,
    input dcmmt_pkg::sample_t m_min_first,
    input dcmmt_pkg::sample_t m_mean_first,
    input dcmmt_pkg::count_t  m_count_second,
    input dcmmt_pkg::sample_t m_max_second,
    input dcmmt_pkg::sample_t m_min_second,
    input dcmmt_pkg::sample_t m_mean_second,
    input logic               m_full_flag
);

    // one request in flight: ready drops after every accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an accepted beat");

    // stalled result beat holds its counts and means
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_first) && $stable(m_mean_second)
            && $stable(m_count_first) && $stable(m_count_second))
        else $error("result beat changed while stalled");

    // mean lies between min and max on both channels
    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_min_first <= m_mean_first && m_mean_first <= m_max_first
            && m_min_second <= m_mean_second && m_mean_second <= m_max_second)
        else $error("mean outside min/max range");

    // a rejected sample implies a channel sits at its count limit
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_flag |-> m_count_first == dcmmt_pkg::COUNT_MAX
            || m_count_second == dcmmt_pkg::COUNT_MAX)
        else $error("full flag without a full count");

endmodule

bind dual_channel_min_max_mean_tracker dcmmt_checker u_dcmmt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_count_first  (m_count_first),
    .m_max_first    (m_max_first),
    .m_min_first    (m_min_first),
    .m_mean_first   (m_mean_first),
    .m_count_second (m_count_second),
    .m_max_second   (m_max_second),
    .m_min_second   (m_min_second),
    .m_mean_second  (m_mean_second),
    .m_full_flag    (m_full_flag)
);

// ----- verif/dual_channel_min_max_mean_tracker_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dual_channel_min_max_mean_tracker: directed and random request
// beats, a running statistics predictor per channel, beat-by-beat result checks.
// Depends on dcmmt_pkg and the tracker RTL only.
module dual_channel_min_max_mean_tracker_tb;

    // run shape
    localparam int TOTAL_BEATS  = 1950;   // request beats, directed part included
    localparam int QUIET_FROM   = 1650;   // no idling or stalls from this beat on
    localparam int SETTLE_CYCLES = 40;    // exceeds one request's accept-to-result time, plus margin
    // worst correct beat spans a sender gap, the compute and a held result
    // under a receiver stall; this limit covers the run several times over
    localparam int CYCLE_LIMIT  = 600000;

    // one request beat as driven on the s_ channel
    typedef struct packed {
        logic               req_type;
        logic               clear_channel;
        dcmmt_pkg::sample_t sample_first;
        dcmmt_pkg::sample_t sample_second;
    } stats_req_t;

    // one result beat as seen on the m_ channel
    typedef struct packed {
        dcmmt_pkg::count_t  count_first;
        dcmmt_pkg::sample_t max_first;
        dcmmt_pkg::sample_t min_first;
        dcmmt_pkg::sample_t mean_first;
        dcmmt_pkg::count_t  count_second;
        dcmmt_pkg::sample_t max_second;
        dcmmt_pkg::sample_t min_second;
        dcmmt_pkg::sample_t mean_second;
        logic               full_flag;
    } stats_view_t;

    // Scoreboard: tracks per-channel peak, trough, count and sum, and queues the
    // statistics view each accepted request should produce.
    class channel_stats_board;
        logic [dcmmt_pkg::NUM_CH-1:0][dcmmt_pkg::SAMPLE_BITS-1:0] peak;
        logic [dcmmt_pkg::NUM_CH-1:0][dcmmt_pkg::SAMPLE_BITS-1:0] trough;
        logic [dcmmt_pkg::NUM_CH-1:0][dcmmt_pkg::COUNT_BITS-1:0]  count;
        logic [dcmmt_pkg::NUM_CH-1:0][dcmmt_pkg::SUM_BITS-1:0]    sum;
        stats_view_t pending_stats[$];
        int errors     = 0;
        int n_samples  = 0;
        int n_clears   = 0;
        int n_checked  = 0;
        int top_count  = 0;

        function new();
            peak   = '0;
            trough = '0;
            count  = '0;
            sum    = '0;
        endfunction

        // returns 1 when the channel is at its count limit and drops the sample
        function logic absorb(int ch, dcmmt_pkg::sample_t s);
            if (count[ch] == dcmmt_pkg::COUNT_MAX)
                return 1'b1;
            if (s > peak[ch])
                peak[ch] = s;
            if (count[ch] == '0 || s < trough[ch])
                trough[ch] = s;
            count[ch] = count[ch] + 1'b1;
            sum[ch]   = sum[ch] + dcmmt_pkg::sum_t'(s);
            if (int'(count[ch]) > top_count)
                top_count = int'(count[ch]);
            return 1'b0;
        endfunction

        function dcmmt_pkg::sample_t mean_of(int ch);
            dcmmt_pkg::sum_t q;
            if (count[ch] == '0)
                return '0;
            q = sum[ch] / count[ch];
            return q[dcmmt_pkg::SAMPLE_BITS-1:0];
        endfunction

        function void note_request(stats_req_t r);
            stats_view_t v;
            logic dropped;
            dropped = 1'b0;
            if (r.req_type == dcmmt_pkg::REQ_CLEAR) begin
                peak[r.clear_channel]   = '0;
                trough[r.clear_channel] = '0;
                count[r.clear_channel]  = '0;
                sum[r.clear_channel]    = '0;
                n_clears++;
            end else begin
                dropped = absorb(0, r.sample_first);
                dropped = absorb(1, r.sample_second) | dropped;
                n_samples++;
            end
            v.count_first  = count[0];
            v.max_first    = peak[0];
            v.min_first    = trough[0];
            v.mean_first   = mean_of(0);
            v.count_second = count[1];
            v.max_second   = peak[1];
            v.min_second   = trough[1];
            v.mean_second  = mean_of(1);
            v.full_flag    = dropped;
            pending_stats.push_back(v);
        endfunction

        function void compare(string field, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(stats_view_t got);
            stats_view_t want;
            if (pending_stats.size() == 0) begin
                $display("%0t: result beat with nothing outstanding", $time);
                errors++;
                return;
            end
            want = pending_stats.pop_front();
            n_checked++;
            compare("count_first",  want.count_first,  got.count_first);
            compare("max_first",    want.max_first,    got.max_first);
            compare("min_first",    want.min_first,    got.min_first);
            compare("mean_first",   want.mean_first,   got.mean_first);
            compare("count_second", want.count_second, got.count_second);
            compare("max_second",   want.max_second,   got.max_second);
            compare("min_second",   want.min_second,   got.min_second);
            compare("mean_second",  want.mean_second,  got.mean_second);
            compare("full_flag",    want.full_flag,    got.full_flag);
        endfunction

        function int outstanding();
            return pending_stats.size();
        endfunction
    endclass

    // DUT ports
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic               s_clear_channel;
    dcmmt_pkg::sample_t s_sample_first;
    dcmmt_pkg::sample_t s_sample_second;
    logic               m_valid;
    logic               m_ready;
    dcmmt_pkg::count_t  m_count_first;
    dcmmt_pkg::sample_t m_max_first;
    dcmmt_pkg::sample_t m_min_first;
    dcmmt_pkg::sample_t m_mean_first;
    dcmmt_pkg::count_t  m_count_second;
    dcmmt_pkg::sample_t m_max_second;
    dcmmt_pkg::sample_t m_min_second;
    dcmmt_pkg::sample_t m_mean_second;
    logic               m_full_flag;

    channel_stats_board board;
    int  beats_sent  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b0;   // sender may insert idle bursts
    bit  stall_on    = 1'b0;   // receiver may insert stall bursts

    dual_channel_min_max_mean_tracker DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_clear_channel (s_clear_channel),
        .s_sample_first  (s_sample_first),
        .s_sample_second (s_sample_second),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_count_first   (m_count_first),
        .m_max_first     (m_max_first),
        .m_min_first     (m_min_first),
        .m_mean_first    (m_mean_first),
        .m_count_second  (m_count_second),
        .m_max_second    (m_max_second),
        .m_min_second    (m_min_second),
        .m_mean_second   (m_mean_second),
        .m_full_flag     (m_full_flag)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog. Counts every edge from time zero, reset included.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, board.outstanding());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: m_ready changes on the falling edge only. Stalls come in
    // random bursts while stall_on is set; otherwise ready stays high.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Result monitor: a beat moves at the rising edge with m_valid and m_ready high.
    // Outputs are read before the edge's register updates land.
    always @(posedge aclk) begin : result_monitor
        stats_view_t got;
        if (aresetn && m_valid && m_ready) begin
            got.count_first  = m_count_first;
            got.max_first    = m_max_first;
            got.min_first    = m_min_first;
            got.mean_first   = m_mean_first;
            got.count_second = m_count_second;
            got.max_second   = m_max_second;
            got.min_second   = m_min_second;
            got.mean_second  = m_mean_second;
            got.full_flag    = m_full_flag;
            board.check_result(got);
        end
    end

    // Sample request; clear_channel is don't-care here so it gets a random value.
    function automatic stats_req_t sample_req(dcmmt_pkg::sample_t a, dcmmt_pkg::sample_t b);
        stats_req_t r;
        r.req_type      = dcmmt_pkg::REQ_SAMPLE;
        r.clear_channel = 1'($urandom_range(0, 1));
        r.sample_first  = a;
        r.sample_second = b;
        return r;
    endfunction

    // Clear request; both sample fields are ignored by the block, so randomize them.
    function automatic stats_req_t clear_req(logic ch);
        stats_req_t r;
        r.req_type      = dcmmt_pkg::REQ_CLEAR;
        r.clear_channel = ch;
        r.sample_first  = dcmmt_pkg::sample_t'($urandom_range(0, 4095));
        r.sample_second = dcmmt_pkg::sample_t'($urandom_range(0, 4095));
        return r;
    endfunction

    // Sample value shapes for the random episodes:
    //   0 full range, 1 rails and near-rails, 2 narrow window above a base,
    //   3 walking single bit set or cleared.
    function automatic dcmmt_pkg::sample_t pick_sample(int shape, dcmmt_pkg::sample_t base);
        dcmmt_pkg::sample_t one_hot;
        case (shape)
            1: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 12'd1;
                    2: return 12'hFFE;
                    default: return 12'hFFF;
                endcase
            end
            2: begin
                if (int'(base) + 15 > 4095)
                    return dcmmt_pkg::sample_t'(4095 - $urandom_range(0, 15));
                return dcmmt_pkg::sample_t'(int'(base) + $urandom_range(0, 15));
            end
            3: begin
                one_hot = dcmmt_pkg::sample_t'(1)
                          << $urandom_range(0, dcmmt_pkg::SAMPLE_BITS - 1);
                return $urandom_range(0, 1) ? one_hot : ~one_hot;
            end
            default: return dcmmt_pkg::sample_t'($urandom_range(0, 4095));
        endcase
    endfunction

    // Drive one request beat. Payload changes on the falling edge; the beat is
    // taken at the first rising edge that sees s_ready. Valid stays high on
    // return so back-to-back beats keep it up without a glitch.
    task automatic send_request(input stats_req_t r);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_req_type      = r.req_type;
        s_clear_channel = r.clear_channel;
        s_sample_first  = r.sample_first;
        s_sample_second = r.sample_second;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_request(r);
        beats_sent++;
        // last stretch of the run goes without idling or stalls
        if (beats_sent >= QUIET_FROM) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
        end
        @(negedge aclk);
    endtask

    initial begin
        stats_req_t r;
        int shape;
        int run_len;
        dcmmt_pkg::sample_t base_a;
        dcmmt_pkg::sample_t base_b;

        board = new();

        // all inputs known from time zero
        s_valid         = 1'b0;
        s_req_type      = dcmmt_pkg::REQ_SAMPLE;
        s_clear_channel = 1'b0;
        s_sample_first  = '0;
        s_sample_second = '0;

        // single reset pulse, released on a falling edge
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // ---- directed part ----
        // fresh after reset: first sample sets min even when it is zero
        send_request(sample_req(12'd0,   12'd0));
        send_request(sample_req(12'hFFF, 12'hFFF));
        send_request(sample_req(12'hFFF, 12'd0));
        send_request(sample_req(12'd1,   12'hFFE));
        send_request(sample_req(12'h800, 12'h7FF));
        // clear first channel, then clear it again while already empty
        send_request(clear_req(1'b0));
        send_request(clear_req(1'b0));
        // min after a clear must come from the first new sample, not from zero
        send_request(sample_req(12'h555, 12'hAAA));
        send_request(sample_req(12'hAAA, 12'h555));
        send_request(clear_req(1'b1));
        send_request(sample_req(12'd7,   12'hFFF));
        // both channels empty: means read zero
        send_request(clear_req(1'b0));
        send_request(clear_req(1'b1));
        send_request(sample_req(12'hFFF, 12'd0));
        send_request(sample_req(12'd0,   12'hFFF));
        send_request(sample_req(12'hFFF, 12'hFFF));

        // ---- random part ----
        // Episodes: optional clears, then a run of samples drawn from one value
        // shape, with the odd stray clear mixed in. Most runs are short so counts
        // restart often; some run long so sums and means get exercised deeper.
        while (beats_sent < TOTAL_BEATS) begin
            idle_on  = (beats_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            stall_on = (beats_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            shape    = $urandom_range(0, 3);
            base_a   = dcmmt_pkg::sample_t'($urandom_range(0, 4095));
            base_b   = dcmmt_pkg::sample_t'($urandom_range(0, 4095));
            run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                1: send_request(clear_req(1'b0));
                2: send_request(clear_req(1'b1));
                3: begin
                    send_request(clear_req(1'b0));
                    send_request(clear_req(1'b1));
                end
                default: ;
            endcase
            for (int i = 0; i < run_len && beats_sent < TOTAL_BEATS; i++) begin
                if ($urandom_range(0, 29) == 0)
                    r = clear_req(1'($urandom_range(0, 1)));
                else
                    r = sample_req(pick_sample(shape, base_a), pick_sample(shape, base_b));
                send_request(r);
            end
        end

        // ---- drain ----
        s_valid  = 1'b0;
        idle_on  = 1'b0;
        stall_on = 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        // let any stray extra beat show up before judging
        repeat (SETTLE_CYCLES) @(posedge aclk);
        board.errors += board.outstanding();

        $display("Covered %0d sample and %0d clear requests, %0d result beats checked,",
                 board.n_samples, board.n_clears, board.n_checked);
        $display("deepest channel count %0d, in %0d cycles.", board.top_count, cycle_count);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
